@@ sv/ptbls_pkg.sv @@
// Package for the best-parent link table.
// Holds field widths, status codes and the stored entry type; no dependencies.
package ptbls_pkg;

    localparam int ADDR_W = 16;
    localparam int MET_W  = 16;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_UPDATED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_SELECTED = 2'd3;

    localparam logic [MET_W-1:0] NO_ROUTE_METRIC = 16'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [MET_W-1:0]  metric;
    } entry_t;

    localparam int ENTRY_W = ADDR_W + MET_W;

endpackage

@@ sv/ptbls_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ptbls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/parent_table_best_link_select.sv @@
// Best-parent link table: beacon insert/update and best-metric select.
// Depends on ptbls_pkg and ptbls_ram.
//
//   channel  | handshake        | payload
//   ---------+------------------+-----------------------------------
//   command  | start / busy     | mode, node_addr, link_metric
//   result   | done (strobe)    | status, best_addr, best_metric
//
// An item walks the table RAM between the transfer and the done strobe, one
// entry read per cycle; a beacon that matches ends at that entry.
// busy is high from the transfer until done; start is ignored meanwhile.
// Reset clears the entry count and control; RAM contents need no clearing.
// done is high for one cycle and the receiver cannot stall it.
module parent_table_best_link_select
    import ptbls_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              mode,
    input  logic [ADDR_W-1:0] node_addr,
    input  logic [MET_W-1:0]  link_metric,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic [ADDR_W-1:0] best_addr,
    output logic [MET_W-1:0]  best_metric
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              rv_reg, rv_next;
    logic              mode_reg, mode_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [MET_W-1:0]  met_reg, met_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] baddr_reg, baddr_next;
    logic [MET_W-1:0]  bmet_reg, bmet_next;
    logic              done_reg, done_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0] oaddr_reg, oaddr_next;
    logic [MET_W-1:0]  omet_reg, omet_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            rd_entry;

    ptbls_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        rd_idx_next = rd_idx_reg;
        rv_next     = 1'b0;
        mode_next   = mode_reg;
        addr_next   = addr_reg;
        met_next    = met_reg;
        found_next  = found_reg;
        baddr_next  = baddr_reg;
        bmet_next   = bmet_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        oaddr_next  = oaddr_reg;
        omet_next   = omet_reg;
        ram_we      = 1'b0;
        ram_waddr   = rd_idx_reg;
        ram_wdata   = '{addr: addr_reg, metric: met_reg};
        ram_re      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    addr_next  = node_addr;
                    met_next   = link_metric;
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    ram_re      = 1'b1;
                    rd_idx_next = idx_reg[IDX_W-1:0];
                    idx_next    = idx_reg + CNT_W'(1);
                    rv_next     = 1'b1;
                end

                if (rv_reg && !mode_reg)
                begin
                    if (rd_entry.addr == addr_reg)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = rd_idx_reg;
                        rv_next     = 1'b0;
                        done_next   = 1'b1;
                        status_next = ST_UPDATED;
                        oaddr_next  = '0;
                        omet_next   = '0;
                        state_next  = S_IDLE;
                    end
                end
                else if (rv_reg)
                begin
                    if (rd_entry.metric != NO_ROUTE_METRIC &&
                        (!found_reg || rd_entry.metric >= bmet_reg))
                    begin
                        found_next = 1'b1;
                        bmet_next  = rd_entry.metric;
                        baddr_next = rd_entry.addr;
                    end
                end
                else if (idx_reg == count_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (mode_reg)
                    begin
                        status_next = ST_SELECTED;
                        oaddr_next  = found_reg ? baddr_reg : '0;
                        omet_next   = found_reg ? bmet_reg : NO_ROUTE_METRIC;
                    end
                    else
                    begin
                        oaddr_next = '0;
                        omet_next  = '0;
                        if (count_reg >= CNT_FULL)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = count_reg[IDX_W-1:0];
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_INSERTED;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
        mode_reg   <= mode_next;
        addr_reg   <= addr_next;
        met_reg    <= met_next;
        found_reg  <= found_next;
        baddr_reg  <= baddr_next;
        bmet_reg   <= bmet_next;
        status_reg <= status_next;
        oaddr_reg  <= oaddr_next;
        omet_reg   <= omet_next;
    end

    assign busy        = state_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign best_addr   = oaddr_reg;
    assign best_metric = omet_reg;

endmodule
